// File: hdl/modinv_pkg.sv
// Shared widths and control structs for the modular inverse block.
`default_nettype none
package modinv_pkg;

  localparam int FIELD_W   = 63;
  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 64;

  // Requests from the stream wrapper to the Euclid engine.
  typedef struct packed {
    logic start;     // operands on the engine inputs are taken this cycle
    logic res_free;  // the output register can take a result this cycle
  } core_ctrl_t;

  // Status from the engine back to the stream wrapper.
  typedef struct packed {
    logic idle;      // engine can take a new pair of operands
    logic done;      // result on the engine outputs is valid this cycle
    logic exists;    // gcd was one, so the inverse is meaningful
  } core_stat_t;

endpackage
`default_nettype wire

// File: hdl/modinv_core.sv
// Iterative extended Euclid engine built on one shared subtractor.
`default_nettype none
module modinv_core #(
  parameter int WORD_BITS = 64,
  localparam int OPND_W = WORD_BITS - 1,
  localparam int K_W = $clog2(OPND_W),
  localparam int SUB_W = OPND_W + 2
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire modinv_pkg::core_ctrl_t ctrl,
  input  wire  [OPND_W-1:0]          value,
  input  wire  [OPND_W-1:0]          modulus,
  output modinv_pkg::core_stat_t     stat,
  output logic [OPND_W-1:0]          inverse
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    ALIGN = 5'b00010,
    SUB   = 5'b00100,
    FIN1  = 5'b01000,
    FIN2  = 5'b10000
  } state_t;

  state_t state;

  // Remainder pair, coefficient magnitudes, shifted divisor and coefficient.
  logic [OPND_W-1:0] r0, r1, u0, u1, d, e, modr;
  logic [K_W-1:0]    k;
  logic              odd;
  logic              bad;

  logic [SUB_W-1:0]  sub_a, sub_b, diff;
  logic              borrow;
  logic [OPND_W-1:0] dlo;
  logic [OPND_W-1:0] coef_sum;
  logic [OPND_W-1:0] r0_next, u0_next;
  logic              ok;

  // The one subtractor; its operands depend on the step being taken.
  always_comb begin
    case (state)
      ALIGN: begin
        sub_a = SUB_W'(r0);
        sub_b = SUB_W'({d, 1'b0});
      end
      SUB: begin
        sub_a = SUB_W'(r0);
        sub_b = SUB_W'(d);
      end
      FIN1: begin
        sub_a = SUB_W'(u0);
        sub_b = SUB_W'(modr);
      end
      FIN2: begin
        sub_a = SUB_W'(modr);
        sub_b = SUB_W'(u0);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff     = sub_a - sub_b;
  assign borrow   = diff[SUB_W-1];
  assign dlo      = diff[OPND_W-1:0];
  assign coef_sum = u0 + e;
  assign r0_next  = borrow ? r0 : dlo;
  assign u0_next  = borrow ? u0 : coef_sum;
  assign ok       = !bad && (r0 == OPND_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (ctrl.start) begin
            // Starting with (modulus, value) unreduced: a value above the modulus
            // costs one extra zero-quotient step and is reduced by the next one.
            r0    <= modulus;
            r1    <= value;
            u0    <= '0;
            u1    <= OPND_W'(1);
            d     <= value;
            e     <= OPND_W'(1);
            k     <= '0;
            odd   <= 1'b0;
            modr  <= modulus;
            bad   <= (modulus == '0);
            state <= (modulus == '0) ? FIN1 : ALIGN;
          end
        end
        ALIGN: begin
          if (r1 == '0) begin
            state <= FIN1;
          end else if (!borrow) begin
            d <= {d[OPND_W-2:0], 1'b0};
            e <= {e[OPND_W-2:0], 1'b0};
            k <= k + K_W'(1);
          end else begin
            state <= SUB;
          end
        end
        SUB: begin
          if (k == '0) begin
            // Last quotient bit: finish the remainder and rotate the pairs.
            r0    <= r1;
            r1    <= r0_next;
            u0    <= u1;
            u1    <= u0_next;
            d     <= r0_next;
            e     <= u0_next;
            odd   <= !odd;
            state <= ALIGN;
          end else begin
            r0 <= r0_next;
            u0 <= u0_next;
            d  <= {1'b0, d[OPND_W-1:1]};
            e  <= {1'b0, e[OPND_W-1:1]};
            k  <= k - K_W'(1);
          end
        end
        FIN1: begin
          // The coefficient never exceeds the modulus, so one subtract reduces it.
          if (!borrow) begin
            u0 <= dlo;
          end
          state <= FIN2;
        end
        FIN2: begin
          if (ctrl.res_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (!ok) begin
      inverse = '0;
    end else if (odd) begin
      inverse = u0;
    end else if (u0 == '0) begin
      inverse = '0;
    end else begin
      inverse = dlo;
    end
  end

  assign stat.idle   = (state == IDLE);
  assign stat.done   = (state == FIN2) && ctrl.res_free;
  assign stat.exists = ok;

endmodule
`default_nettype wire

// File: hdl/modular_inverse.sv
// Stream wrapper and output register around the modular inverse engine.
//
// Takes a value and a modulus and returns the inverse of the value modulo the
// modulus in 0..modulus-1, with exists set when gcd(value, modulus) is one;
// otherwise inverse is 0 and exists is clear. A modulus of one gives 0 with
// exists set, a zero modulus gives 0 with exists clear. Operands are
// WORD_BITS-1 bits wide and higher input bits are ignored. One item is worked
// at a time: s_tready drops after a transfer and returns when the result has
// been written into the output register. The time per item is data dependent
// and set by the Euclid loop running on one shared subtractor: each division
// step aligns the divisor and then subtracts once per bit of its quotient (a
// zero quotient, which a value above the modulus adds once, counts as one
// bit), and the setup in IDLE and the finish in FIN1 and FIN2 add to it. A
// zero modulus skips the loop. A new item is taken while an earlier result
// still waits on m_tready.
`default_nettype none
module modular_inverse #(
  parameter int WORD_BITS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // s_tdata fields, lowest bit up: value[62:0], modulus[125:63], zero fill.
  input  wire  [modinv_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // m_tdata fields, lowest bit up: inverse[62:0], zero fill.
  output logic [modinv_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tuser fields, lowest bit up: exists[0].
  output logic                                m_tuser
);

  localparam int OPND_W = WORD_BITS - 1;
  localparam int FW     = modinv_pkg::FIELD_W;

  modinv_pkg::core_ctrl_t ctrl;
  modinv_pkg::core_stat_t stat;
  logic [OPND_W-1:0]      core_inverse;
  logic [OPND_W-1:0]      in_value, in_modulus;

  assign in_value   = s_tdata[OPND_W-1:0];
  assign in_modulus = s_tdata[FW+OPND_W-1:FW];

  assign s_tready      = stat.idle;
  assign ctrl.start    = s_tvalid && s_tready;
  assign ctrl.res_free = !m_tvalid || m_tready;

  modinv_core #(
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .value  (in_value),
    .modulus(in_modulus),
    .stat   (stat),
    .inverse(core_inverse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      m_tdata <= modinv_pkg::M_TDATA_W'(core_inverse);
      m_tuser <= stat.exists;
    end
  end

`ifndef SYNTHESIS
  // A result is only written when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (!m_tvalid || m_tready))
    else $error("result written over a pending transfer");

  // The engine is busy in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while engine busy");

  // A missing inverse is always reported as zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("nonzero inverse without exists");

  // No result can appear while a new item is being started.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !stat.done)
    else $error("start and done in the same cycle");
`endif

endmodule
`default_nettype wire
